[design/sfc_pkg.sv]
// ----------------------------------------------------------------------------
// Sensor frame checker package
// Shared beat types, status codes and the byte-wide reflected CRC-16 update.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  HDR_FUNCTION = 8'h03;
    localparam logic [7:0]  HDR_LENGTH   = 8'h04;

    // Positions of the bytes within one response frame.
    localparam logic [2:0] POS_FUNCTION = 3'd0;
    localparam logic [2:0] POS_LENGTH   = 3'd1;
    localparam logic [2:0] POS_HUM_HI   = 3'd2;
    localparam logic [2:0] POS_HUM_LO   = 3'd3;
    localparam logic [2:0] POS_TEMP_HI  = 3'd4;
    localparam logic [2:0] POS_TEMP_LO  = 3'd5;
    localparam logic [2:0] POS_CRC_LO   = 3'd6;
    localparam logic [2:0] POS_CRC_HI   = 3'd7;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_HDR = 2'd1,
        ST_BAD_CRC = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_beat_t;

    typedef struct packed {
        status_t            status;
        logic signed [15:0] temperature_tenths;
        logic [15:0]        humidity_tenths;
    } out_beat_t;

    // Everything the result stage needs when the last byte of a frame arrives.
    typedef struct packed {
        logic        done;
        logic        header_ok;
        logic        crc_match;
        logic [15:0] humidity_raw;
        logic [15:0] temperature_raw;
    } frame_done_t;

    // One byte into a reflected CRC-16, least significant bit first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[design/sfc_if.sv]
// ----------------------------------------------------------------------------
// Sensor frame checker channels
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
interface sfc_in_if;
    logic             valid;
    logic             ready;
    sfc_pkg::in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sfc_out_if;
    logic               valid;
    logic               ready;
    sfc_pkg::out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/sfc_frame.sv]
// ----------------------------------------------------------------------------
// Sensor frame checker: frame tracker
// Counts bytes, runs the CRC over bytes 0..5 and captures the data fields.
// ----------------------------------------------------------------------------
module sfc_frame (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  sfc_pkg::in_beat_t    beat,
    output sfc_pkg::frame_done_t frame
);
    import sfc_pkg::*;

    logic [2:0]  byte_count_reg, byte_count_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic        header_ok_reg, header_ok_next;
    logic [15:0] humidity_raw_reg, humidity_raw_next;
    logic [15:0] temperature_raw_reg, temperature_raw_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    logic [2:0]  pos;
    logic [15:0] crc_base;
    logic        hdr_base;
    logic        last_byte;

    // A frame start drops the partial frame; its byte is byte 0.
    assign pos       = beat.frame_start ? POS_FUNCTION : byte_count_reg;
    assign crc_base  = beat.frame_start ? CRC_INIT : running_crc_reg;
    assign hdr_base  = beat.frame_start ? 1'b1 : header_ok_reg;
    assign last_byte = (pos == POS_CRC_HI);

    always_comb
    begin
        byte_count_next      = byte_count_reg;
        running_crc_next     = running_crc_reg;
        header_ok_next       = header_ok_reg;
        humidity_raw_next    = humidity_raw_reg;
        temperature_raw_next = temperature_raw_reg;
        crc_low_next         = crc_low_reg;
        if (accept)
        begin
            byte_count_next  = pos + 3'd1;
            running_crc_next = crc_base;
            header_ok_next   = hdr_base;
            if (pos <= POS_TEMP_LO)
            begin
                running_crc_next = crc_feed(crc_base, beat.rx_byte);
            end
            case (pos)
                POS_FUNCTION: header_ok_next = (beat.rx_byte == HDR_FUNCTION);
                POS_LENGTH:   header_ok_next = hdr_base && (beat.rx_byte == HDR_LENGTH);
                POS_HUM_HI:   humidity_raw_next[15:8] = beat.rx_byte;
                POS_HUM_LO:   humidity_raw_next[7:0] = beat.rx_byte;
                POS_TEMP_HI:  temperature_raw_next[15:8] = beat.rx_byte;
                POS_TEMP_LO:  temperature_raw_next[7:0] = beat.rx_byte;
                POS_CRC_LO:   crc_low_next = beat.rx_byte;
                default:
                begin
                    // Last byte: the frame state starts over for the next frame.
                    running_crc_next = CRC_INIT;
                    header_ok_next   = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg      <= 3'd0;
            running_crc_reg     <= CRC_INIT;
            header_ok_reg       <= 1'b1;
            humidity_raw_reg    <= 16'd0;
            temperature_raw_reg <= 16'd0;
            crc_low_reg         <= 8'd0;
        end
        else
        begin
            byte_count_reg      <= byte_count_next;
            running_crc_reg     <= running_crc_next;
            header_ok_reg       <= header_ok_next;
            humidity_raw_reg    <= humidity_raw_next;
            temperature_raw_reg <= temperature_raw_next;
            crc_low_reg         <= crc_low_next;
        end
    end

    assign frame.done            = accept && last_byte;
    assign frame.header_ok       = header_ok_reg;
    assign frame.crc_match       = ({beat.rx_byte, crc_low_reg} == running_crc_reg);
    assign frame.humidity_raw    = humidity_raw_reg;
    assign frame.temperature_raw = temperature_raw_reg;

`ifndef ASSERT_OFF
    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        frame.done |=> (byte_count_reg == 3'd0) && (running_crc_reg == CRC_INIT)
                       && header_ok_reg)
        else $error("frame state not cleared after the last byte");

    a_start_is_byte0: assert property (@(posedge clk) disable iff (!rst_n)
        accept && beat.frame_start |=> (byte_count_reg == 3'd1))
        else $error("frame start did not restart the byte count");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(byte_count_reg) && $stable(running_crc_reg))
        else $error("frame state moved without an accepted beat");
`endif

endmodule

[design/sfc_result.sv]
// ----------------------------------------------------------------------------
// Sensor frame checker: result stage
// Forms the status and converted readings and holds them in the result register.
// ----------------------------------------------------------------------------
module sfc_result (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfc_pkg::frame_done_t frame,
    output logic                 slot_free,
    sfc_out_if.source            res_ch
);
    import sfc_pkg::*;

    logic      res_valid_reg, res_valid_next;
    out_beat_t res_data_reg, res_data_next;
    out_beat_t formed;
    logic [14:0] mag;

    assign mag = frame.temperature_raw[14:0];

    always_comb
    begin
        formed.status             = ST_OK;
        formed.temperature_tenths = 16'sd0;
        formed.humidity_tenths    = 16'd0;
        if (!frame.header_ok)
        begin
            formed.status = ST_BAD_HDR;
        end
        else if (!frame.crc_match)
        begin
            formed.status = ST_BAD_CRC;
        end
        else
        begin
            // Sign-magnitude to two's complement; negative zero stays zero.
            if (frame.temperature_raw[15])
            begin
                formed.temperature_tenths = -$signed({1'b0, mag});
            end
            else
            begin
                formed.temperature_tenths = $signed({1'b0, mag});
            end
            formed.humidity_tenths = frame.humidity_raw;
        end
    end

    assign slot_free = !res_valid_reg || res_ch.ready;

    always_comb
    begin
        res_valid_next = res_valid_reg && !res_ch.ready;
        res_data_next  = res_data_reg;
        if (frame.done)
        begin
            res_valid_next = 1'b1;
            res_data_next  = formed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_ch.valid = res_valid_reg;
    assign res_ch.data  = res_data_reg;

`ifndef ASSERT_OFF
    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_data_reg.status != ST_OK)
            |-> (res_data_reg.temperature_tenths == 16'sd0)
                && (res_data_reg.humidity_tenths == 16'd0))
        else $error("readings not zero on an error status");

    a_no_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_data_reg.temperature_tenths != 16'sh8000))
        else $error("negative zero leaked into the temperature");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        frame.done |-> slot_free)
        else $error("result overwritten before it was taken");
`endif

endmodule

[design/sensor_frame_checker_crc16.sv]
// ----------------------------------------------------------------------------
// Sensor frame checker, CRC-16
// Checks 8-byte sensor response frames and returns status and readings.
// ----------------------------------------------------------------------------
//   channel  dir  payload                                           beats
//   rx_ch    in   rx_byte, frame_start                              one per byte
//   res_ch   out  status, temperature_tenths, humidity_tenths       one per frame
//
// One byte is taken every cycle while rx_ch.ready is high; the CRC update for
// a byte is one unrolled step in the frame tracker. The result of a frame sits
// in the result register in the cycle after its last byte. rx_ch.ready drops
// only while a result waits and res_ch.ready is low. Reset clears the byte
// count and result valid, presets CRC and header flag; there is no clearing pass.
module sensor_frame_checker_crc16 (
    input  logic      clk,
    input  logic      rst_n,
    sfc_in_if.sink    rx_ch,
    sfc_out_if.source res_ch
);
    import sfc_pkg::*;

    logic        accept;
    logic        slot_free;
    frame_done_t frame;

    assign rx_ch.ready = slot_free;
    assign accept      = rx_ch.valid && slot_free;

    sfc_frame u_frame (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .beat   (rx_ch.data),
        .frame  (frame)
    );

    sfc_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame),
        .slot_free (slot_free),
        .res_ch    (res_ch)
    );

endmodule
